// ===== rtl/dht_pkg.sv =====
// Shared types and constants for the double-hashing hash table.
// No dependencies; imported by every module of the block.
package dht_pkg;

    localparam int KEY_W      = 31;
    localparam int VALUE_W    = 32;
    localparam int SLOT_W     = 10;
    localparam int DIGIT_BITS = 4;
    localparam int DIV_W      = 32;
    localparam int DIV_STEPS  = DIV_W / DIGIT_BITS;
    localparam int STEP_W     = 3;

    // Probe step base: the step is this minus (key mod 7).
    localparam logic [STEP_W-1:0] STEP_BASE = 3'd7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_NOT_FOUND = 2'd1,
        RC_FULL      = 2'd2
    } result_e;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_TOMB  = 2'd2
    } slot_st_e;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } dht_state_e;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] entry_value;
    } dht_req_t;

    typedef struct packed {
        logic [1:0]         result_code;
        logic [VALUE_W-1:0] found_value;
        logic [SLOT_W-1:0]  slot_index;
    } dht_rsp_t;

    typedef struct packed {
        slot_st_e           status;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } dht_slot_t;

endpackage

// ===== rtl/dht_mod_unit.sv =====
// Iterative remainder unit: key mod TABLE_SIZE and key mod 7, four bits a cycle.
// Depends on dht_pkg.
module dht_mod_unit #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dht_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [$clog2(TABLE_SIZE)-1:0] rem_size,
    output logic [dht_pkg::STEP_W-1:0] rem_seven
);
    import dht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W:0] SIZE_W = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [STEP_W:0] SEVEN = (STEP_W+1)'(7);
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_W-1:0]     shift_reg, shift_next;
    logic [IDX_W:0]       rn_reg, rn_next;
    logic [STEP_W-1:0]    r7_reg, r7_next;

    // One cycle of restoring reduction: four dependent shift-and-subtract steps.
    always_comb
    begin
        logic [IDX_W:0]  rn;
        logic [STEP_W:0] r7;
        logic            b;
        rn = rn_reg;
        r7 = {1'b0, r7_reg};
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            b  = shift_reg[DIV_W-1-i];
            rn = {rn[IDX_W-1:0], b};
            if (rn >= SIZE_W)
            begin
                rn = rn - SIZE_W;
            end
            r7 = {r7[STEP_W-1:0], b};
            if (r7 >= SEVEN)
            begin
                r7 = r7 - SEVEN;
            end
        end

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rn_next    = rn_reg;
        r7_next    = r7_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = {1'b0, key};
            rn_next    = '0;
            r7_next    = '0;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << DIGIT_BITS;
            rn_next    = rn;
            r7_next    = r7[STEP_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rn_reg    <= rn_next;
        r7_reg    <= r7_next;
    end

    assign done      = done_reg;
    assign rem_size  = rn_reg[IDX_W-1:0];
    assign rem_seven = r7_reg;

endmodule

// ===== rtl/double_hash_table_unit.sv =====
// Top level of the double-hashing hash table: slot memory, probe sequencer, result register.
// Depends on dht_pkg and dht_mod_unit.
//
// Usage: a request word (opcode, key, entry_value) enters on req_valid/req_ready and
// exactly one response word (result_code, found_value, slot_index) leaves on
// rsp_valid/rsp_ready for each request. Insert takes the first slot that is empty or a
// tombstone; delete and search stop at a matching key, an empty slot or after
// TABLE_SIZE probes. After reset the block sweeps the slot memory, one slot per
// cycle, marking every slot empty, and req_ready stays low meanwhile.
// Sequence: the remainder unit first reduces the key (mod TABLE_SIZE and mod 7,
// four key bits a cycle); then each probe reads the single-port memory and checks
// the slot; then the response register is loaded. An unused opcode skips hashing
// and goes straight to the response. One request is in flight at a time.
// A response that is not taken stays in its register; the next request is accepted
// and processed meanwhile, and its response waits until the register frees.
module double_hash_table_unit #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dht_pkg::dht_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dht_pkg::dht_rsp_t rsp
);
    import dht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W:0]   SIZE_W   = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W:0]   LAST_CNT = (IDX_W+1)'(TABLE_SIZE - 1);

    dht_state_e          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W:0]      cnt_reg, cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    result_e             code_reg, code_next;
    logic [VALUE_W-1:0]  fval_reg, fval_next;
    logic [IDX_W-1:0]    fslot_reg, fslot_next;
    logic                out_valid_reg, out_valid_next;
    dht_rsp_t            out_reg, out_next;

    logic                accept;
    logic                op_ok;
    logic                mod_start;
    logic                mod_done;
    logic [IDX_W-1:0]    mod_rem;
    logic [STEP_W-1:0]   mod_rem7;

    dht_slot_t           mem [TABLE_SIZE];
    dht_slot_t           rd_q;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_addr;
    dht_slot_t           mem_wdata;

    logic                chk_finish;
    logic                chk_write;
    result_e             chk_code;
    logic [VALUE_W-1:0]  chk_val;
    dht_slot_t           chk_wdata;
    logic [IDX_W:0]      idx_sum;
    logic [IDX_W-1:0]    idx_adv;
    logic                out_free;
    logic [IDX_W+SLOT_W-1:0] slot_wide;

    dht_mod_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .key       (req.key),
        .done      (mod_done),
        .rem_size  (mod_rem),
        .rem_seven (mod_rem7)
    );

    assign accept   = req_valid && req_ready;
    assign op_ok    = (req.opcode == OP_INSERT) || (req.opcode == OP_DELETE) ||
                      (req.opcode == OP_SEARCH);
    assign out_free = !out_valid_reg || rsp_ready;

    // Next probe slot; the step is at most 7; the user must keep the table at 8 slots or more (not enforced here).
    assign idx_sum = {1'b0, idx_reg} + {{(IDX_W+1-STEP_W){1'b0}}, step_reg};
    assign idx_adv = (idx_sum >= SIZE_W) ? IDX_W'(idx_sum - SIZE_W) : idx_sum[IDX_W-1:0];

    // Examine the slot just read.
    always_comb
    begin
        chk_finish = 1'b0;
        chk_write  = 1'b0;
        chk_code   = RC_OK;
        chk_val    = '0;
        chk_wdata  = rd_q;
        if (op_reg == OP_INSERT)
        begin
            if (rd_q.status != ST_USED)
            begin
                chk_finish = 1'b1;
                chk_write  = 1'b1;
                chk_wdata  = '{status: ST_USED, key: key_reg, value: val_reg};
            end
            else if (cnt_reg == LAST_CNT)
            begin
                chk_finish = 1'b1;
                chk_code   = RC_FULL;
            end
        end
        else
        begin
            if (rd_q.status == ST_EMPTY)
            begin
                chk_finish = 1'b1;
                chk_code   = RC_NOT_FOUND;
            end
            else if (rd_q.status == ST_USED && rd_q.key == key_reg)
            begin
                chk_finish = 1'b1;
                if (op_reg == OP_DELETE)
                begin
                    chk_write        = 1'b1;
                    chk_wdata.status = ST_TOMB;
                end
                else
                begin
                    chk_val = rd_q.value;
                end
            end
            else if (cnt_reg == LAST_CNT)
            begin
                chk_finish = 1'b1;
                chk_code   = RC_NOT_FOUND;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = op_ok ? S_HASH : S_DONE;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = chk_finish ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req_ready = 1'b0;
        mod_start = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = idx_reg;
        mem_wdata = chk_wdata;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{status: ST_EMPTY, key: '0, value: '0};
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                mod_start = req_valid && op_ok;
            end
            S_CHECK:
            begin
                mem_we = chk_write;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        code_next      = code_reg;
        fval_next      = fval_reg;
        fslot_next     = fslot_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.opcode;
                    key_next   = req.key;
                    val_next   = req.entry_value;
                    code_next  = RC_NOT_FOUND;
                    fval_next  = '0;
                    fslot_next = '0;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    idx_next  = mod_rem;
                    step_next = STEP_BASE - mod_rem7;
                    cnt_next  = '0;
                end
            end
            S_CHECK:
            begin
                if (chk_finish)
                begin
                    code_next  = chk_code;
                    fval_next  = chk_val;
                    fslot_next = (chk_code == RC_OK) ? idx_reg : '0;
                end
                else
                begin
                    idx_next = idx_adv;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{result_code: code_reg, found_value: fval_reg,
                                       slot_index: slot_wide[SLOT_W-1:0]};
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    assign slot_wide = {{SLOT_W{1'b0}}, fslot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        code_reg  <= code_next;
        fval_reg  <= fval_next;
        fslot_reg <= fslot_next;
        out_reg   <= out_next;
    end

    // Slot memory: one port, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_q <= mem[mem_addr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== rtl/dht_checker.sv =====
// Port-level checks for the double-hashing hash table, bound to its top level.
// Depends on dht_pkg and double_hash_table_unit.
module dht_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input dht_pkg::dht_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input dht_pkg::dht_rsp_t rsp
);
    import dht_pkg::*;

    // A stalled response word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // A failed operation reports no value and no slot.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_code != RC_OK |-> rsp.found_value == '0 &&
        rsp.slot_index == '0)
        else $error("failed operation carries data");

    // The block does not take a request in the cycle after it takes one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on consecutive cycles");

    // Only searches return a value, so a found value is never paired with a failure.
    a_value_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found_value != '0 |-> rsp.result_code == RC_OK)
        else $error("value returned with failure code");

endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/dht_shadow_check.sv =====
// Response checker for double_hash_table_unit: watches both handshakes, keeps a shadow
// copy of the slot table and compares every response word with its prediction.
// Depends on dht_pkg only.
module dht_shadow_check #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  dht_pkg::dht_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  dht_pkg::dht_rsp_t rsp,
    output int                fail_count,
    output int                pending,
    output int                insert_count,
    output int                delete_count,
    output int                search_count,
    output int                unused_count,
    output int                full_count,
    output int                miss_count
);
    import dht_pkg::*;

    localparam int MAX_REPORTS = 10;

    slot_st_e         shadow_state [TABLE_SIZE];
    bit [KEY_W-1:0]   shadow_key   [TABLE_SIZE];
    bit [VALUE_W-1:0] shadow_data  [TABLE_SIZE];
    dht_rsp_t         pending_rsp  [$];

    // Applies one request word to the shadow table and returns the response it should get.
    function automatic dht_rsp_t apply_request(input dht_req_t w);
        int unsigned key_u;
        int unsigned pos;
        int unsigned stride;
        dht_rsp_t    answer;
        key_u  = w.key;
        pos    = key_u % TABLE_SIZE;
        stride = STEP_BASE - (key_u % 7);
        answer = '0;
        answer.result_code = RC_NOT_FOUND;
        case (w.opcode)
            OP_INSERT:
            begin
                answer.result_code = RC_FULL;
                for (int probe = 0; probe < TABLE_SIZE; probe++)
                begin
                    // Tombstones are free for an insert; duplicates are not looked for.
                    if (shadow_state[pos] != ST_USED)
                    begin
                        shadow_state[pos]  = ST_USED;
                        shadow_key[pos]    = w.key;
                        shadow_data[pos]   = w.entry_value;
                        answer.result_code = RC_OK;
                        answer.slot_index  = pos[SLOT_W-1:0];
                        break;
                    end
                    pos = (pos + stride) % TABLE_SIZE;
                end
            end
            OP_DELETE, OP_SEARCH:
            begin
                for (int probe = 0; probe < TABLE_SIZE; probe++)
                begin
                    if (shadow_state[pos] == ST_EMPTY)
                        break;
                    if (shadow_state[pos] == ST_USED && shadow_key[pos] == w.key)
                    begin
                        answer.result_code = RC_OK;
                        answer.slot_index  = pos[SLOT_W-1:0];
                        if (w.opcode == OP_DELETE)
                            shadow_state[pos] = ST_TOMB;
                        else
                            answer.found_value = shadow_data[pos];
                        break;
                    end
                    pos = (pos + stride) % TABLE_SIZE;
                end
            end
            default:
            begin
            end
        endcase
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dht_rsp_t want;
        if (!rst_n)
        begin
            foreach (shadow_state[i])
                shadow_state[i] = ST_EMPTY;
            pending_rsp.delete();
            fail_count   = 0;
            insert_count = 0;
            delete_count = 0;
            search_count = 0;
            unused_count = 0;
            full_count   = 0;
            miss_count   = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Unexpected response word: code %0d value %h slot %0d",
                                 rsp.result_code, rsp.found_value, rsp.slot_index);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.result_code !== want.result_code
                        || rsp.found_value !== want.found_value
                        || rsp.slot_index !== want.slot_index)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("Mismatch: expected code %0d value %h slot %0d, got code %0d value %h slot %0d",
                                     want.result_code, want.found_value, want.slot_index,
                                     rsp.result_code, rsp.found_value, rsp.slot_index);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_request(req);
                pending_rsp.push_back(want);
                case (req.opcode)
                    OP_INSERT: insert_count++;
                    OP_DELETE: delete_count++;
                    OP_SEARCH: search_count++;
                    default:   unused_count++;
                endcase
                if (want.result_code == RC_FULL)
                    full_count++;
                else if (want.result_code == RC_NOT_FOUND)
                    miss_count++;
            end
        end
        pending = pending_rsp.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for double_hash_table_unit: clock, reset, request and response drivers,
// watchdog and verdict. Depends on dht_pkg, dht_shadow_check and the RTL.
module tb_top;
    import dht_pkg::*;

    localparam int               TABLE_SIZE   = 1024;
    localparam logic [1:0]       OP_UNUSED    = 2'd3;
    localparam int               RANDOM_WORDS = 800;
    localparam int               POOL_SIZE    = 40;
    localparam int               STALL_LIMIT  = 12000;
    localparam int               HOLD_OFF     = 400;
    localparam int               DRAIN_CYCLES = 40;
    localparam logic [KEY_W-1:0] KEY_MAX      = '1;
    // Slot 36 with a step of 4: this key only ever probes slots that are multiples of four.
    localparam logic [KEY_W-1:0] STRIDE4_KEY  = 31'd1060;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    dht_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    dht_rsp_t rsp;

    int send_idle_pct  = 29;
    int recv_idle_pct  = 86;
    bit want_long_hold = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int fail_count;
    int pending;
    int insert_count;
    int delete_count;
    int search_count;
    int unused_count;
    int full_count;
    int miss_count;

    double_hash_table_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    dht_shadow_check #(
        .TABLE_SIZE(TABLE_SIZE)
    ) shadow_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending      (pending),
        .insert_count (insert_count),
        .delete_count (delete_count),
        .search_count (search_count),
        .unused_count (unused_count),
        .full_count   (full_count),
        .miss_count   (miss_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offers one request word and returns at the edge where it is taken.
    task automatic drive_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v);
        dht_req_t w;
        w.opcode      = op;
        w.key         = k;
        w.entry_value = v;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    initial
    begin : receiver
        int  hold;
        bit  hold_started;
        hold         = 0;
        hold_started = 1'b0;
        forever
        begin
            @(negedge clk);
            if (want_long_hold && !hold_started)
            begin
                hold_started = 1'b1;
                hold         = HOLD_OFF;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int               roll;
        logic [KEY_W-1:0] pick;
        logic [VALUE_W-1:0] fill_value;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Fill every slot that is a multiple of four, so a stride-4 key finds no room.
        for (int i = 0; i < TABLE_SIZE / 4; i++)
        begin
            fill_value = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
            drive_word(OP_INSERT, 4 * i, fill_value);
        end
        drive_word(OP_INSERT, STRIDE4_KEY, 32'h1234_5678);
        drive_word(OP_SEARCH, STRIDE4_KEY, '0);
        drive_word(OP_DELETE, STRIDE4_KEY, '0);
        // Free one slot in that class; the stride-4 key then wraps around to reach it.
        drive_word(OP_DELETE, 31'd8, '0);
        drive_word(OP_INSERT, STRIDE4_KEY, '1);
        drive_word(OP_SEARCH, STRIDE4_KEY, '0);
        drive_word(OP_SEARCH, 31'd8, '0);

        // Two keys sharing slot 3; deleting the first must not cut the chain to the second.
        drive_word(OP_INSERT, 31'd3, '0);
        drive_word(OP_INSERT, 31'd1027, 32'hA5A5_5A5A);
        drive_word(OP_DELETE, 31'd3, '0);
        drive_word(OP_SEARCH, 31'd1027, '0);
        drive_word(OP_SEARCH, 31'd3, '0);
        drive_word(OP_INSERT, 31'd1027, 32'h0F0F_F0F0);
        drive_word(OP_SEARCH, 31'd1027, '0);
        drive_word(OP_DELETE, 31'd1027, '0);
        drive_word(OP_SEARCH, 31'd1027, '0);

        drive_word(OP_INSERT, KEY_MAX, '1);
        drive_word(OP_SEARCH, KEY_MAX, '0);
        drive_word(OP_DELETE, KEY_MAX, '1);
        drive_word(OP_SEARCH, KEY_MAX, '0);
        drive_word(OP_SEARCH, 31'd1, '0);
        drive_word(OP_UNUSED, KEY_MAX, '1);
        drive_word(OP_UNUSED, '0, '0);
        drive_word(OP_INSERT, '0, '0);
        drive_word(OP_SEARCH, '0, '0);

        // A mixed key pool gives hits, collisions on one slot and keys near the top.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case (i % 4)
                0:       key_pool[i] = $urandom;
                1:       key_pool[i] = $urandom_range(2047);
                2:       key_pool[i] = 100 + 1024 * $urandom_range(2000000);
                default: key_pool[i] = KEY_MAX - $urandom_range(255);
            endcase
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 29;
            end
            if (n == 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct  = 0;
                recv_idle_pct  = 0;
                want_long_hold = 1'b1;
            end
            roll = $urandom_range(99);
            pick = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (roll < 8)
                drive_word($urandom_range(OP_UNUSED), $urandom, $urandom);
            else if (roll < 48)
                drive_word(OP_INSERT, pick, $urandom);
            else if (roll < 72)
                drive_word(OP_DELETE, pick, $urandom);
            else
                drive_word(OP_SEARCH, pick, $urandom);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d inserts, %0d deletes, %0d searches and %0d unused-opcode words.",
                 insert_count, delete_count, search_count, unused_count);
        $display("It saw %0d table-full and %0d not-found answers, and a %0d-cycle response stall.",
                 full_count, miss_count, HOLD_OFF);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
